>>> design/sirt_pkg.sv
`default_nettype none

package sirt_pkg;

   localparam int SIRT_WORD_BITS = 32;

   localparam int SIRT_RADIX_W = 3;
   localparam int SIRT_CHAR_W  = 7;
   localparam int SIRT_DIGIT_W = 5;
   localparam int SIRT_ADDR_W  = 3;
   localparam int SIRT_DATA_W  = 32;

   localparam logic [SIRT_RADIX_W-1:0] RADIX_MIN   = 3'd1;
   localparam logic [SIRT_RADIX_W-1:0] RADIX_MAX   = 3'd5;
   localparam logic [SIRT_RADIX_W-1:0] RADIX_RESET = 3'd1;

   localparam logic [SIRT_RADIX_W-1:0] RADIX_BITS_1 = 3'd1;
   localparam logic [SIRT_RADIX_W-1:0] RADIX_BITS_2 = 3'd2;
   localparam logic [SIRT_RADIX_W-1:0] RADIX_BITS_3 = 3'd3;
   localparam logic [SIRT_RADIX_W-1:0] RADIX_BITS_4 = 3'd4;
   localparam logic [SIRT_RADIX_W-1:0] RADIX_BITS_5 = 3'd5;

   localparam logic REG_RADIX_BITS = 1'b0;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_BAD_RADIX = 1'b1;

   localparam logic [SIRT_CHAR_W-1:0] MINUS_CHAR = 7'h2D;
   localparam logic [SIRT_CHAR_W-1:0] ERROR_CHAR = 7'h00;
   localparam logic [SIRT_CHAR_W-1:0] ZERO_CHAR  = 7'h30;
   localparam logic [SIRT_CHAR_W-1:0] ALPHA_BASE = 7'h37;

   localparam logic [SIRT_DIGIT_W-1:0] DECIMAL_LIMIT = 5'd10;

   typedef logic [SIRT_CHAR_W-1:0] char_type;

   function automatic char_type digit_char(input logic [SIRT_DIGIT_W-1:0] d);
      char_type c;
      if (d < DECIMAL_LIMIT) begin
         c = ZERO_CHAR + {2'b00, d};
      end else begin
         c = ALPHA_BASE + {2'b00, d};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> design/signed_int_to_pow2_radix_text_core.sv
`default_nettype none

// Channel  | Ports                                      | Moves
// ---------+--------------------------------------------+--------------------------------
// req      | req_valid, req_stall, req_value            | one signed integer per beat
// rsp      | rsp_valid, rsp_stall, rsp_out_char,        | one ASCII character per beat
//          | rsp_status, rsp_last                       |
// csr      | psel, penable, pwrite, paddr, pwdata,      | radix_bits at address 0
//          | prdata, pready                             |
//
// An integer passes four register stages (capture, magnitude, leading-one search, top
// digit index) and then the character emitter, which sends one character per cycle unless
// rsp_stall holds it. A run is 1 to WORD_BITS+1 characters; the emitter takes a new integer
// only after the last character of the previous run has been sent.
// Synchronous active-high reset empties every stage and sets radix_bits to 1.
// rsp_stall holds the output register and the emitter; the stages fill and then req_stall rises.

module signed_int_to_pow2_radix_text_core #(
   parameter int WORD_BITS = sirt_pkg::SIRT_WORD_BITS
) (
   input  wire                                   clock,
   input  wire                                   reset,

   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  signed [WORD_BITS-1:0]           req_value,

   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [sirt_pkg::SIRT_CHAR_W-1:0]      rsp_out_char,
   output logic                                  rsp_status,
   output logic                                  rsp_last,

   input  wire                                   psel,
   input  wire                                   penable,
   input  wire                                   pwrite,
   input  wire  [sirt_pkg::SIRT_ADDR_W-1:0]      paddr,
   input  wire  [sirt_pkg::SIRT_DATA_W-1:0]      pwdata,
   output logic [sirt_pkg::SIRT_DATA_W-1:0]      prdata,
   output logic                                  pready
);

   import sirt_pkg::*;

   localparam int POS_W       = $clog2(WORD_BITS);
   localparam int SHIFT_W     = POS_W + SIRT_RADIX_W;
   localparam int RECIP_SHIFT = 11;
   localparam int PROD_W      = POS_W + RECIP_SHIFT;
   localparam logic [PROD_W-1:0] DIV3_RECIP = PROD_W'(683);
   localparam logic [PROD_W-1:0] DIV5_RECIP = PROD_W'(410);

   // configuration register
   logic [SIRT_RADIX_W-1:0] radix_ff;
   logic [SIRT_RADIX_W-1:0] radix_in;
   logic                    csr_write;
   logic                    csr_hit;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[SIRT_ADDR_W-1] == REG_RADIX_BITS);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign radix_in  = csr_write ? pwdata[SIRT_RADIX_W-1:0] : radix_ff;
   assign prdata    = csr_hit ? {{(SIRT_DATA_W-SIRT_RADIX_W){1'b0}}, radix_ff}
                              : {SIRT_DATA_W{1'b0}};

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   // stage 1: capture
   logic                    s1_valid_ff;
   logic [WORD_BITS-1:0]    s1_value_ff;
   logic [SIRT_RADIX_W-1:0] s1_radix_ff;
   logic                    s1_free;

   // stage 2: magnitude
   logic                    s2_valid_ff;
   logic [WORD_BITS-1:0]    s2_mag_ff;
   logic [WORD_BITS-1:0]    s2_mag_in;
   logic                    s2_neg_ff;
   logic                    s2_err_ff;
   logic                    s2_err_in;
   logic [SIRT_RADIX_W-1:0] s2_radix_ff;
   logic                    s2_free;

   // stage 3: leading one
   logic                    s3_valid_ff;
   logic [WORD_BITS-1:0]    s3_mag_ff;
   logic                    s3_neg_ff;
   logic                    s3_err_ff;
   logic [SIRT_RADIX_W-1:0] s3_radix_ff;
   logic [POS_W-1:0]        s3_msb_ff;
   logic [POS_W-1:0]        s3_msb_in;
   logic                    s3_free;

   // stage 4: top digit index
   logic                    s4_valid_ff;
   logic [WORD_BITS-1:0]    s4_mag_ff;
   logic                    s4_neg_ff;
   logic                    s4_err_ff;
   logic [SIRT_RADIX_W-1:0] s4_radix_ff;
   logic [POS_W-1:0]        s4_top_ff;
   logic [POS_W-1:0]        s4_top_in;
   logic                    s4_free;

   // emitter
   logic                    em_busy_ff;
   logic                    em_minus_ff;
   logic                    em_err_ff;
   logic [WORD_BITS-1:0]    em_mag_ff;
   logic [SIRT_RADIX_W-1:0] em_radix_ff;
   logic [POS_W-1:0]        em_pos_ff;
   logic                    em_load;
   logic                    em_fire;
   logic                    em_done;
   logic [SHIFT_W-1:0]      em_shift;
   logic [WORD_BITS-1:0]    em_shifted;
   logic [SIRT_DIGIT_W-1:0] em_mask;
   logic [SIRT_DIGIT_W-1:0] em_digit;

   // output register
   logic                    rsp_valid_ff;
   char_type                rsp_char_ff;
   logic                    rsp_status_ff;
   logic                    rsp_last_ff;
   logic                    out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign em_fire  = em_busy_ff && out_free;
   assign em_done  = em_fire && (em_err_ff || (!em_minus_ff && em_pos_ff == '0));
   assign em_load  = !em_busy_ff && s4_valid_ff;

   assign s4_free  = !s4_valid_ff || em_load;
   assign s3_free  = !s3_valid_ff || s4_free;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;

   assign s2_err_in = (s1_radix_ff < RADIX_MIN) || (s1_radix_ff > RADIX_MAX);
   assign s2_mag_in = s1_value_ff[WORD_BITS-1] ? (~s1_value_ff + WORD_BITS'(1)) : s1_value_ff;

   always_comb begin
      s3_msb_in = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (s2_mag_ff[i]) begin
            s3_msb_in = POS_W'(i);
         end
      end
   end

   always_comb begin
      case (s3_radix_ff)
         RADIX_BITS_1: s4_top_in = s3_msb_ff;
         RADIX_BITS_2: s4_top_in = s3_msb_ff >> 1;
         RADIX_BITS_3: s4_top_in = POS_W'((PROD_W'(s3_msb_ff) * DIV3_RECIP) >> RECIP_SHIFT);
         RADIX_BITS_4: s4_top_in = s3_msb_ff >> 2;
         RADIX_BITS_5: s4_top_in = POS_W'((PROD_W'(s3_msb_ff) * DIV5_RECIP) >> RECIP_SHIFT);
         default:      s4_top_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_free) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_value_ff <= req_value;
         s1_radix_ff <= radix_ff;
      end
      if (s2_free) begin
         s2_mag_ff   <= s2_mag_in;
         s2_neg_ff   <= s1_value_ff[WORD_BITS-1];
         s2_err_ff   <= s2_err_in;
         s2_radix_ff <= s1_radix_ff;
      end
      if (s3_free) begin
         s3_mag_ff   <= s2_mag_ff;
         s3_neg_ff   <= s2_neg_ff;
         s3_err_ff   <= s2_err_ff;
         s3_radix_ff <= s2_radix_ff;
         s3_msb_ff   <= s3_msb_in;
      end
      if (s4_free) begin
         s4_mag_ff   <= s3_mag_ff;
         s4_neg_ff   <= s3_neg_ff;
         s4_err_ff   <= s3_err_ff;
         s4_radix_ff <= s3_radix_ff;
         s4_top_ff   <= s4_top_in;
      end
   end

   assign em_shift   = SHIFT_W'(em_pos_ff) * SHIFT_W'(em_radix_ff);
   assign em_shifted = em_mag_ff >> em_shift;
   assign em_mask    = SIRT_DIGIT_W'((6'd1 << em_radix_ff) - 6'd1);
   assign em_digit   = em_shifted[SIRT_DIGIT_W-1:0] & em_mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         em_busy_ff <= 1'b0;
      end else if (em_load) begin
         em_busy_ff <= 1'b1;
      end else if (em_done) begin
         em_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (em_load) begin
         em_mag_ff   <= s4_mag_ff;
         em_radix_ff <= s4_radix_ff;
         em_err_ff   <= s4_err_ff;
         em_minus_ff <= s4_neg_ff && !s4_err_ff;
         em_pos_ff   <= s4_top_ff;
      end else if (em_fire && !em_err_ff) begin
         if (em_minus_ff) begin
            em_minus_ff <= 1'b0;
         end else if (em_pos_ff != '0) begin
            em_pos_ff <= em_pos_ff - POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= em_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (em_fire) begin
         if (em_err_ff) begin
            rsp_char_ff   <= ERROR_CHAR;
            rsp_status_ff <= STATUS_BAD_RADIX;
            rsp_last_ff   <= 1'b1;
         end else if (em_minus_ff) begin
            rsp_char_ff   <= MINUS_CHAR;
            rsp_status_ff <= STATUS_OK;
            rsp_last_ff   <= 1'b0;
         end else begin
            rsp_char_ff   <= digit_char(em_digit);
            rsp_status_ff <= STATUS_OK;
            rsp_last_ff   <= (em_pos_ff == '0);
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sirt_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 64;
   localparam int PHASES       = 10;

   localparam logic [SIRT_ADDR_W-1:0] RADIX_ADDR  = SIRT_ADDR_W'(REG_RADIX_BITS) << 2;
   localparam logic [SIRT_ADDR_W-1:0] UNUSED_ADDR = RADIX_ADDR + SIRT_ADDR_W'(4);

   localparam string DIGIT_TEXT = "0123456789ABCDEFGHIJKLMNOPQRSTUV";

   typedef struct {
      char_type ch;
      logic     st;
      logic     lst;
   } text_beat_type;

   class radix_text_board;
      text_beat_type             expected_text [$];
      logic [SIRT_RADIX_W-1:0]   radix;
      int                        errors;

      function new();
         radix  = RADIX_RESET;
         errors = 0;
      endfunction

      function void set_radix(logic [SIRT_RADIX_W-1:0] r);
         radix = r;
      endfunction

      function int pending();
         return expected_text.size();
      endfunction

      function void note_value(logic signed [SIRT_WORD_BITS-1:0] v);
         logic [SIRT_WORD_BITS-1:0] mag;
         logic [SIRT_WORD_BITS-1:0] dmask;
         logic [SIRT_DIGIT_W-1:0]   digs [SIRT_WORD_BITS];
         int                        nd;
         text_beat_type             b;
         nd = 0;
         if (radix < RADIX_MIN || radix > RADIX_MAX) begin
            b.ch  = ERROR_CHAR;
            b.st  = STATUS_BAD_RADIX;
            b.lst = 1'b1;
            expected_text.push_back(b);
            return;
         end
         mag   = v[SIRT_WORD_BITS-1] ? ~v + 1'b1 : v;
         dmask = (SIRT_WORD_BITS'(1) << radix) - 1'b1;
         while (mag != 0) begin
            digs[nd] = SIRT_DIGIT_W'(mag & dmask);
            nd++;
            mag = mag >> radix;
         end
         b.st = STATUS_OK;
         if (nd == 0) begin
            b.ch  = ZERO_CHAR;
            b.lst = 1'b1;
            expected_text.push_back(b);
            return;
         end
         if (v[SIRT_WORD_BITS-1]) begin
            b.ch  = MINUS_CHAR;
            b.lst = 1'b0;
            expected_text.push_back(b);
         end
         for (int i = nd - 1; i >= 0; i--) begin
            b.ch  = char_type'(DIGIT_TEXT[digs[i]]);
            b.lst = (i == 0);
            expected_text.push_back(b);
         end
      endfunction

      function void check_char(char_type ch, logic st, logic lst);
         text_beat_type e;
         if (expected_text.size() == 0) begin
            $error("unexpected beat: out_char %h status %b last %b", ch, st, lst);
            errors++;
            return;
         end
         e = expected_text.pop_front();
         if (ch !== e.ch) begin
            $error("out_char: expected %h, got %h", e.ch, ch);
            errors++;
         end
         if (st !== e.st) begin
            $error("status: expected %b, got %b", e.st, st);
            errors++;
         end
         if (lst !== e.lst) begin
            $error("last: expected %b, got %b", e.lst, lst);
            errors++;
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   wire                              req_stall;
   logic signed [SIRT_WORD_BITS-1:0] req_value;
   wire                              rsp_valid;
   logic                             rsp_stall;
   wire  [SIRT_CHAR_W-1:0]           rsp_out_char;
   wire                              rsp_status;
   wire                              rsp_last;
   logic                             psel;
   logic                             penable;
   logic                             pwrite;
   logic [SIRT_ADDR_W-1:0]           paddr;
   logic [SIRT_DATA_W-1:0]           pwdata;
   wire  [SIRT_DATA_W-1:0]           prdata;
   wire                              pready;

   radix_text_board board;
   logic            steady;
   logic            squeeze_go;
   int              cycle_count;

   logic signed [SIRT_WORD_BITS-1:0] corner_values [0:15] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001,
      32'sd2, -32'sd2, 32'sd31, 32'sd32, -32'sd32, 32'sh4000_0000,
      32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_FFFF, 32'shFFFF_0000
   };

   logic [SIRT_RADIX_W-1:0] radix_plan [0:PHASES-1] = '{
      RADIX_BITS_5, 3'd0, RADIX_BITS_3, RADIX_BITS_2, 3'd7,
      RADIX_BITS_4, 3'd6, RADIX_BITS_1, RADIX_BITS_5, RADIX_BITS_2
   };

   signed_int_to_pow2_radix_text_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   // receiver: random stall, one long hold-off on request
   initial begin
      int  hold_left;
      bit  squeeze_done;
      hold_left    = 0;
      squeeze_done = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            board.check_char(rsp_out_char, rsp_status, rsp_last);
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (squeeze_go && !squeeze_done) begin
            squeeze_done = 1;
            hold_left    = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < 23);
         end
      end
   end

   task automatic send_value(input logic signed [SIRT_WORD_BITS-1:0] v);
      while (!steady && ($urandom_range(99) < 23)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_stall);
      board.note_value(v);
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [SIRT_ADDR_W-1:0] addr,
                            input logic [SIRT_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == RADIX_ADDR) begin
         board.set_radix(data[SIRT_RADIX_W-1:0]);
      end
   endtask

   initial begin
      logic signed [SIRT_WORD_BITS-1:0] v;
      int                               count;
      board      = new();
      steady     = 1'b0;
      squeeze_go = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_values[i]) send_value(corner_values[i]);
      end_burst();

      for (int p = 0; p < PHASES; p++) begin
         if (p == 1) csr_write(UNUSED_ADDR, $urandom);
         csr_write(RADIX_ADDR, {(SIRT_DATA_W-SIRT_RADIX_W)'($urandom), radix_plan[p]});
         steady = (p == 4);
         if (p == 2) squeeze_go = 1'b1;
         count = $urandom_range(12, 20);
         repeat (count) begin
            case ($urandom_range(9))
               0, 1: v = corner_values[$urandom_range(15)];
               2, 3, 4: begin
                  v = $urandom >> $urandom_range(31);
                  if ($urandom_range(1)) v = -v;
               end
               default: v = $urandom;
            endcase
            send_value(v);
         end
         end_burst();
      end
      steady = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
